// File: rtl/cst_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cst_pkg
// Shared types and codes for the CBOR stream tokenizer.
// ---------------------------------------------------------------------------
package cst_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_message;
    logic [31:0] bytes_after;
  } in_word_t;

  typedef struct packed {
    logic        token_valid;
    logic [3:0]  token_kind;
    logic [63:0] argument;
    logic [6:0]  item_depth;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        message_ok;
    logic [2:0]  error_code;
  } out_word_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED = 3'd1;
  localparam logic [2:0] ERR_BAD_INFO  = 3'd2;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd3;
  localparam logic [2:0] ERR_COUNT     = 3'd4;
  localparam logic [2:0] ERR_SIMPLE    = 3'd5;
  localparam logic [2:0] ERR_TRAILING  = 3'd6;

  localparam logic [3:0] TK_ARRAY = 4'd4;
  localparam logic [3:0] TK_MAP   = 4'd5;
  localparam logic [3:0] TK_TAG   = 4'd6;
  localparam logic [3:0] TK_FALSE = 4'd7;
  localparam logic [3:0] TK_TRUE  = 4'd8;
  localparam logic [3:0] TK_NULL  = 4'd9;

  localparam logic [4:0] INFO_ARG1  = 5'd24;
  localparam logic [4:0] INFO_ARG8  = 5'd27;
  localparam logic [4:0] INFO_FALSE = 5'd20;
  localparam logic [4:0] INFO_TRUE  = 5'd21;
  localparam logic [4:0] INFO_NULL  = 5'd22;
  localparam logic [4:0] INFO_UNDEF = 5'd23;

  localparam int QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

// File: rtl/cbor_stream_tokenizer_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbor_stream_tokenizer_top
// Definite-length CBOR tokenizer, one message byte per word.
// ---------------------------------------------------------------------------
// Input words carry a message byte, a first-of-message mark and the count of
// bytes that follow. Every input word yields exactly one result word with a
// token, a payload byte, an end-of-message flag and an error code.
// Throughput: one word per cycle while the receiver does not stall, except
// that a byte finishing an item inside a container that still has items left
// stalls the back end while it writes back that level's decremented count.
// Closing any number of nested levels resolves in one step from per-level
// one-item-left flags. An accepted word passes the front register, then the
// queue, then the result register, before its result is valid.
// Reset clears parse state, the queue and sets max_nesting to 64; the count
// stack needs no clearing. When the receiver stalls, the result register
// holds, the queue fills, and then input stall rises. The user must write
// max_nesting via cfg_we/cfg_data only while idle; the block does not check.
// ---------------------------------------------------------------------------
module cbor_stream_tokenizer_top #(
  parameter int MAX_NEST = 64,
  parameter int LEN_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [6:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire cst_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cst_pkg::out_word_t      out_word
);
  logic [6:0]  max_nesting;
  logic        f_valid;
  logic        f_stall;
  logic [48:0] f_data;
  logic        b_valid;
  logic        b_stall;
  logic [48:0] b_data;

  always_ff @(posedge clk) begin
    if (rst) max_nesting <= 7'd64;
    else if (cfg_we) max_nesting <= cfg_data;
  end

  cst_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_word,
    .q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
  );

  cst_queue #(.WIDTH(49)) u_queue (
    .clk, .rst, .in_valid(f_valid), .in_stall(f_stall), .in_data(f_data),
    .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data)
  );

  cst_back #(.MAX_NEST(MAX_NEST), .LEN_BITS(LEN_BITS)) u_back (
    .clk, .rst, .max_nesting, .q_valid(b_valid), .q_stall(b_stall),
    .q_data(b_data), .out_valid, .out_stall, .out_word
  );
endmodule
`default_nettype wire

// File: rtl/cst_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cst_queue
// Small word queue between two stages, valid/stall on both sides.
// ---------------------------------------------------------------------------
module cst_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [WIDTH-1:0] out_data
);
  localparam int DEPTH = cst_pkg::QUEUE_DEPTH;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_stall  = (count == 2'(DEPTH));
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'(DEPTH))
    else $error("queue overfilled");
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1)
    else $error("queue count lost a push");
  assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> count == $past(count) - 2'd1)
    else $error("queue count lost a pop");
endmodule
`default_nettype wire

// File: rtl/cst_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cst_front
// Takes input bytes and splits each into major type and info fields.
// ---------------------------------------------------------------------------
module cst_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cst_pkg::in_word_t in_word,
  output logic                   q_valid,
  input  wire logic              q_stall,
  output logic [48:0]            q_data
);
  // q_data = {major, info, in_word}
  logic                 full;
  cst_pkg::in_word_t    held;

  assign in_stall = full && q_stall;
  assign q_valid  = full;
  assign q_data   = {held.data_byte[7:5], held.data_byte[4:0], held};

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) held <= in_word;
  end

  assert property (@(posedge clk) disable iff (rst)
    (full && q_stall) |=> full && $stable(held))
    else $error("front register dropped a stalled byte");
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> full)
    else $error("front register lost an accepted byte");
  assert property (@(posedge clk) disable iff (rst)
    q_valid |-> q_data[48:46] == held.data_byte[7:5])
    else $error("major type split wrong");
endmodule
`default_nettype wire

// File: rtl/cst_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cst_back
// Parser state, nesting stack and result register; one byte per cycle
// unless the result is stalled or a level count is being decremented.
// ---------------------------------------------------------------------------
module cst_back #(
  parameter int MAX_NEST = 64,
  parameter int LEN_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [6:0]         max_nesting,
  input  wire logic               q_valid,
  output logic                    q_stall,
  input  wire logic [48:0]        q_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output cst_pkg::out_word_t      out_word
);
  localparam int LW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
  localparam int DW = $clog2(MAX_NEST + 1);

  typedef enum logic [1:0] {PH_HEAD, PH_ARG, PH_STRING, PH_DONE} phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [63:0] accum;
  logic [63:0] accum_next;
  logic [3:0]  arg_left;
  logic [3:0]  arg_left_next;
  logic [2:0]  pend_major;
  logic [2:0]  pend_major_next;
  logic [31:0] str_left;
  logic [31:0] str_left_next;
  logic [DW-1:0] open_lv;
  logic [DW-1:0] open_lv_next;
  logic        root_done;
  logic        root_done_next;
  logic        err;
  logic        err_next;
  logic [32:0] lvl_cnt [MAX_NEST];
  logic [MAX_NEST-1:0] lvl_one;  // per-level "one item left" flag
  logic [MAX_NEST-1:0] lvl_one_next;

  logic              take;
  cst_pkg::in_word_t w;
  logic [2:0]        maj;
  logic [4:0]        info;
  logic [31:0]       rem;
  cst_pkg::out_word_t res;
  logic [2:0]        code;

  // stack write
  logic              st_we;
  logic [LW-1:0]     st_idx;
  logic [32:0]       st_val;

  // count decrement, read now and written back on the following cycle
  logic              dec_req;
  logic [LW-1:0]     dec_req_idx;
  logic              dec_pend;
  logic [LW-1:0]     dec_idx;
  logic [32:0]       dec_cnt;

  assign maj  = q_data[48:46];
  assign info = q_data[45:41];
  assign w    = q_data[40:0];
  assign rem  = (LEN_BITS >= 32) ? w.bytes_after
                : (w.bytes_after & ((32'd1 << LEN_BITS) - 32'd1));
  assign q_stall = (out_valid && out_stall) || dec_pend;
  assign take    = q_valid && !q_stall;

  logic [DW-1:0] limit;
  assign limit = ({2'b00, max_nesting} < 9'(MAX_NEST)) ? DW'(max_nesting) : DW'(MAX_NEST);

  always_comb begin
    logic          clr;
    logic [DW-1:0] lv;
    logic          rd;
    logic          fin;
    logic [2:0]    fm;
    logic [63:0]   n;
    logic          opn;
    logic [32:0]   ocnt;
    logic          cpl;
    logic [DW-1:0] top;
    clr = w.first_of_message;
    phase_next      = clr ? PH_HEAD : phase;
    accum_next      = clr ? 64'd0 : accum;
    arg_left_next   = clr ? 4'd0 : arg_left;
    pend_major_next = clr ? 3'd0 : pend_major;
    str_left_next   = clr ? 32'd0 : str_left;
    open_lv_next    = clr ? '0 : open_lv;
    root_done_next  = clr ? 1'b0 : root_done;
    err_next        = clr ? 1'b0 : err;
    lvl_one_next    = lvl_one;
    lv   = open_lv_next;
    rd   = root_done_next;
    res  = '0;
    code = cst_pkg::ERR_NONE;
    fin  = 1'b0;
    fm   = maj;
    n    = {59'd0, info};
    opn  = 1'b0;
    ocnt = '0;
    cpl  = 1'b0;
    st_we  = 1'b0;
    st_idx = '0;
    st_val = '0;
    dec_req     = 1'b0;
    dec_req_idx = '0;
    top    = '0;
    if (!(err_next || phase_next == PH_DONE)) begin
      unique case (phase_next)
        PH_HEAD: begin
          if (maj == 3'd7) begin
            if (info >= cst_pkg::INFO_FALSE && info <= cst_pkg::INFO_UNDEF) begin
              res.token_valid = 1'b1;
              res.token_kind  = (info == cst_pkg::INFO_FALSE) ? cst_pkg::TK_FALSE :
                                (info == cst_pkg::INFO_TRUE) ? cst_pkg::TK_TRUE :
                                cst_pkg::TK_NULL;
              res.item_depth  = 7'(lv);
              cpl = 1'b1;
            end else begin
              code = cst_pkg::ERR_SIMPLE;
            end
          end else if (info < cst_pkg::INFO_ARG1) begin
            fin = 1'b1;
          end else if (info <= cst_pkg::INFO_ARG8) begin
            if ({28'd0, 4'd1 << info[1:0]} > rem) begin
              code = cst_pkg::ERR_TRUNCATED;
            end else begin
              phase_next      = PH_ARG;
              arg_left_next   = 4'd1 << info[1:0];
              accum_next      = 64'd0;
              pend_major_next = maj;
            end
          end else begin
            code = cst_pkg::ERR_BAD_INFO;
          end
        end
        PH_ARG: begin
          accum_next = {accum_next[55:0], w.data_byte};
          if (arg_left_next != 4'd0) arg_left_next = arg_left_next - 4'd1;
          if (arg_left_next == 4'd0) begin
            phase_next = PH_HEAD;
            fin = 1'b1;
            fm  = pend_major_next;
            n   = accum_next;
          end
        end
        PH_STRING: begin
          res.payload_valid = 1'b1;
          res.payload_byte  = w.data_byte;
          if (str_left_next != 32'd0) str_left_next = str_left_next - 32'd1;
          if (str_left_next == 32'd0) begin
            phase_next = PH_HEAD;
            cpl = 1'b1;
          end
        end
        default: ;
      endcase
      if (fin) begin
        res.argument   = n;
        res.item_depth = 7'(lv);
        res.token_kind = {1'b0, fm};
        unique case (fm)
          3'd0, 3'd1: begin
            res.token_valid = 1'b1;
            cpl = 1'b1;
          end
          3'd2, 3'd3: begin
            if (n > {32'd0, rem}) code = cst_pkg::ERR_TRUNCATED;
            else begin
              res.token_valid = 1'b1;
              if (n == 64'd0) cpl = 1'b1;
              else begin
                str_left_next = n[31:0];
                phase_next = PH_STRING;
              end
            end
          end
          3'd4: begin
            if (n > {32'd0, rem}) code = cst_pkg::ERR_COUNT;
            else begin
              res.token_valid = 1'b1;
              opn = 1'b1;
              ocnt = n[32:0];
            end
          end
          3'd5: begin
            if (n > {33'd0, rem[31:1]}) code = cst_pkg::ERR_COUNT;
            else begin
              res.token_valid = 1'b1;
              opn = 1'b1;
              ocnt = {n[31:0], 1'b0};
            end
          end
          default: begin
            res.token_valid = 1'b1;
            res.token_kind = cst_pkg::TK_TAG;
            opn = 1'b1;
            ocnt = 33'd1;
          end
        endcase
      end
      if (opn) begin
        if (ocnt == 33'd0) cpl = 1'b1;
        else if (lv >= limit) code = cst_pkg::ERR_TOO_DEEP;
        else begin
          st_we  = 1'b1;
          st_idx = LW'(lv);
          st_val = ocnt;
          lvl_one_next[LW'(lv)] = (ocnt == 33'd1);
          lv = lv + DW'(1);
        end
      end
      // completion: pop levels whose last item finishes, decrement the next
      if (cpl && code == cst_pkg::ERR_NONE) begin
        if (lv == '0) rd = 1'b1;
        else begin
          // find deepest level below top that is not at one item left
          top = lv;
          for (int i = MAX_NEST - 1; i >= 0; i--) begin
            if (DW'(i) < lv && !lvl_one_next[i]) begin
              if (top == lv) top = DW'(i);
            end
          end
          if (top == lv) begin
            lv = '0;
            rd = 1'b1;
          end else begin
            dec_req     = 1'b1;
            dec_req_idx = LW'(top);
            lv = top + DW'(1);
          end
        end
      end
      if (code != cst_pkg::ERR_NONE) begin
        res.token_valid = 1'b0;
        res.token_kind  = '0;
        res.argument    = '0;
        res.item_depth  = '0;
        err_next = 1'b1;
        st_we = 1'b0;
        lvl_one_next = lvl_one;
      end else begin
        open_lv_next   = lv;
        root_done_next = rd;
        if (rd && rem != 32'd0) begin
          code = cst_pkg::ERR_TRAILING;
          err_next = 1'b1;
        end else if (rem == 32'd0) begin
          if (rd) begin
            res.message_ok = 1'b1;
            phase_next = PH_DONE;
          end else begin
            code = cst_pkg::ERR_TRUNCATED;
            err_next = 1'b1;
          end
        end
      end
    end
    res.error_code = code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEAD;
      arg_left  <= 4'd0;
      pend_major <= 3'd0;
      str_left  <= 32'd0;
      open_lv   <= '0;
      root_done <= 1'b0;
      err       <= 1'b0;
      out_valid <= 1'b0;
      lvl_one   <= '0;
      dec_pend  <= 1'b0;
    end else begin
      dec_pend <= take && dec_req;
      if (take) begin
        phase      <= phase_next;
        arg_left   <= arg_left_next;
        pend_major <= pend_major_next;
        str_left   <= str_left_next;
        open_lv    <= open_lv_next;
        root_done  <= root_done_next;
        err        <= err_next;
        lvl_one    <= lvl_one_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      // the decrement cycle never coincides with a take
      if (dec_pend) lvl_one[dec_idx] <= (dec_cnt == 33'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accum    <= accum_next;
      out_word <= res;
    end
    if (take && dec_req) begin
      dec_idx <= dec_req_idx;
      dec_cnt <= lvl_cnt[dec_req_idx];
    end
    if (take && st_we) lvl_cnt[st_idx] <= st_val;
    else if (dec_pend) lvl_cnt[dec_idx] <= dec_cnt - 33'd1;
  end

  assert property (@(posedge clk) disable iff (rst) open_lv <= DW'(MAX_NEST))
    else $error("nesting level past stack depth");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_word.token_valid && out_word.payload_valid))
    else $error("token and payload in one word");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.message_ok) |-> out_word.error_code == cst_pkg::ERR_NONE)
    else $error("message ok with error");
endmodule
`default_nettype wire
